### src/grc_pkg.sv
// Shared types and constants for the grid ray caster column block.
// No dependencies; imported by every module of the block.
package grc_pkg;

    localparam int MAP_SIZE      = 64;
    localparam int SCREEN_WIDTH  = 640;
    localparam int SCREEN_HEIGHT = 480;
    localparam int MAX_STEPS     = 128;

    localparam int CELL_W     = 6;
    localparam int MAP_W      = CELL_W + 2;
    localparam int ADDR_W     = 2 * CELL_W;
    localparam int GRID_DEPTH = MAP_SIZE * MAP_SIZE;
    localparam int POS_W      = 16;
    localparam int VEC_W      = 16;
    localparam int TEXW_W     = 11;
    localparam int COL_W      = 10;
    localparam int ROW_W      = 10;
    localparam int CFG_A_W    = 3;
    localparam int CAM_W      = 19;
    localparam int PROD_W     = VEC_W + CAM_W;
    localparam int RAY_W      = 20;
    localparam int DVD_W      = 37;
    localparam int DVR_W      = 24;
    localparam int DCNT_W     = 6;
    localparam int DLT_W      = 41;
    localparam int SD_W       = 48;
    localparam int PERP_W     = 24;
    localparam int LH_W       = 16;
    localparam int NUM_W      = 17;
    localparam int STEP_W     = 8;
    localparam int WPROD_W    = PERP_W + 1 + RAY_W;
    localparam int TXP_W      = 27;
    localparam int HALF_H     = SCREEN_HEIGHT / 2;

    // column * 2^17 / SCREEN_WIDTH by reciprocal multiply, exact for 10-bit columns
    localparam int     CAMP_W  = 32;
    localparam int     CAM_SH  = 14;
    localparam longint CAM_MUL = ((longint'(1) << (17 + CAM_SH)) + SCREEN_WIDTH - 1)
                                 / SCREEN_WIDTH;

    localparam logic OPC_WRITE = 1'b0;
    localparam logic OPC_CAST  = 1'b1;

    typedef enum logic [CFG_A_W-1:0] {
        REG_POS_X,
        REG_POS_Y,
        REG_DIR_X,
        REG_DIR_Y,
        REG_PLANE_X,
        REG_PLANE_Y,
        REG_TEX_WIDTH
    } cfg_reg_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLEAR,
        DP_WRITE,
        DP_LOAD,
        DP_DIV_GO,
        DP_DIV_SAVE,
        DP_RAY_MUL,
        DP_RAY_ADD,
        DP_INIT,
        DP_STEP,
        DP_TEX_MUL,
        DP_TEX_FRAC,
        DP_FIN_HIT,
        DP_FIN_MISS
    } dp_op_t;

    typedef enum logic [2:0] {
        DIV_CAM,
        DIV_DX,
        DIV_DY,
        DIV_PERP,
        DIV_LH
    } div_sel_t;

    typedef struct packed {
        dp_op_t   op;
        div_sel_t div_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic clr_done;
        logic div_busy;
        logic div_done;
        logic oob;
        logic wall;
        logic step_lim;
        logic out_busy;
    } dp_sts_t;

    typedef enum logic [4:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CAM,
        ST_RAY_MUL,
        ST_RAY_ADD,
        ST_DX,
        ST_DX_W,
        ST_DY,
        ST_DY_W,
        ST_INIT,
        ST_STEP,
        ST_CHK,
        ST_PERP,
        ST_PERP_W,
        ST_LH,
        ST_LH_W,
        ST_TEX_MUL,
        ST_TEX_FRAC,
        ST_FIN,
        ST_MISS
    } ctrl_state_t;

endpackage

### src/grc_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Depends on grc_pkg for operand widths.
module grc_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [grc_pkg::DVD_W-1:0]   dividend,
    input  logic [grc_pkg::DVR_W-1:0]   divisor,
    output logic                        busy,
    output logic                        done,
    output logic [grc_pkg::DVD_W-1:0]   quotient
);
    import grc_pkg::*;

    logic [DVD_W-1:0]  qd_reg, qd_next;
    logic [DVR_W-1:0]  rem_reg, rem_next;
    logic [DVR_W-1:0]  dvr_reg, dvr_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              done_reg, done_next;
    logic [DVR_W:0]    trial;
    logic              qbit;

    always_comb
    begin
        trial     = {rem_reg, qd_reg[DVD_W-1]};
        qbit      = (trial >= {1'b0, dvr_reg});
        qd_next   = qd_reg;
        rem_next  = rem_reg;
        dvr_next  = dvr_reg;
        cnt_next  = cnt_reg;
        done_next = 1'b0;
        if (start)
        begin
            qd_next  = dividend;
            rem_next = '0;
            dvr_next = divisor;
            cnt_next = DCNT_W'(DVD_W);
        end
        else if (cnt_reg != '0)
        begin
            // remainder stays below the divisor, so it fits DVR_W bits
            rem_next  = qbit ? DVR_W'(trial - {1'b0, dvr_reg}) : trial[DVR_W-1:0];
            qd_next   = {qd_reg[DVD_W-2:0], qbit};
            cnt_next  = cnt_reg - 1'b1;
            done_next = (cnt_reg == DCNT_W'(1));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        qd_reg  <= qd_next;
        rem_reg <= rem_next;
        dvr_reg <= dvr_next;
    end

    assign busy     = (cnt_reg != '0);
    assign done     = done_reg;
    assign quotient = qd_reg;

endmodule

### src/grc_dp.sv
// Datapath: config registers, wall grid memory, DDA walk, divider and result register.
// Depends on grc_pkg and grc_div.
module grc_dp (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [grc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [grc_pkg::VEC_W-1:0]    cfg_data,
    input  logic [grc_pkg::CELL_W-1:0]   cell_x,
    input  logic [grc_pkg::CELL_W-1:0]   cell_y,
    input  logic                         wall_bit,
    input  logic [grc_pkg::COL_W-1:0]    column,
    input  grc_pkg::dp_cmd_t             cmd,
    output grc_pkg::dp_sts_t             sts,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [grc_pkg::COL_W-1:0]    column_out,
    output logic                         status,
    output logic [grc_pkg::CELL_W-1:0]   hit_x,
    output logic [grc_pkg::CELL_W-1:0]   hit_y,
    output logic                         side,
    output logic [1:0]                   face,
    output logic [grc_pkg::PERP_W-1:0]   perp_dist,
    output logic [grc_pkg::LH_W-1:0]     line_height,
    output logic [grc_pkg::ROW_W-1:0]    draw_start,
    output logic [grc_pkg::ROW_W-1:0]    draw_end,
    output logic [grc_pkg::COL_W-1:0]    tex_x
);
    import grc_pkg::*;

    localparam logic [DLT_W-1:0]  DLT_INF  = {1'b1, {(DLT_W-1){1'b0}}};
    localparam logic [PERP_W-1:0] PERP_MAX = '1;
    localparam logic [LH_W-1:0]   LH_MAX   = '1;
    localparam logic [DVD_W-1:0]  DVD_DLT  = DVD_W'(64'h4000_0000);
    localparam logic [DVD_W-1:0]  DVD_LH   = DVD_W'(SCREEN_HEIGHT * 65536);

    // configuration
    logic [POS_W-1:0]        pos_x_reg, pos_y_reg;
    logic signed [VEC_W-1:0] dir_x_reg, dir_y_reg, plane_x_reg, plane_y_reg;
    logic [TEXW_W-1:0]       tex_width_reg;

    // grid memory
    logic              grid_mem [GRID_DEPTH];
    logic              mem_we, mem_wdata, rd_reg;
    logic [ADDR_W-1:0] mem_waddr, rd_addr;
    logic [ADDR_W:0]   clr_cnt_reg;

    // cast state
    logic [COL_W-1:0]         column_reg;
    logic signed [CAM_W-1:0]  cam_reg;
    logic [CAMP_W-1:0]        cam_prod;
    logic signed [PROD_W-1:0] prod_x_reg, prod_y_reg, prod_x_sh, prod_y_sh;
    logic signed [RAY_W-1:0]  ray_x_reg, ray_y_reg;
    logic [DLT_W-1:0]         dlt_x_reg, dlt_y_reg;
    logic [SD_W-1:0]          sd_x_reg, sd_y_reg;
    logic signed [MAP_W-1:0]  map_x_reg, map_y_reg, map_x_nx, map_y_nx;
    logic [SD_W-1:0]          sd_x_nx, sd_y_nx;
    logic                     side_reg, take_x;
    logic [STEP_W-1:0]        step_cnt_reg;
    logic [PERP_W-1:0]        perp_reg;
    logic [LH_W-1:0]          lh_reg;
    logic signed [WPROD_W-1:0] wprod_reg;
    logic [TXP_W-1:0]         txp_reg;

    // derived values
    logic                neg_x, neg_y, zero_x, zero_y, neg_c, zero_c;
    logic [RAY_W-1:0]    abs_x, abs_y;
    logic [TEXW_W-1:0]   dist_x, dist_y, tw, tx_raw, tx_m;
    logic [41:0]         mul_x, mul_y;
    logic signed [MAP_W-1:0] map_c;
    logic [POS_W-1:0]    pos_c, pos_o;
    logic signed [NUM_W:0] num;
    logic [NUM_W:0]      num_neg;
    logic [NUM_W-1:0]    num_abs;
    logic signed [RAY_W-1:0] ray_o;
    logic [15:0]         frac;
    logic [LH_W-2:0]     half;
    logic [LH_W-1:0]     de_sum;

    // divider
    logic              div_busy, div_done, div_start;
    logic [DVD_W-1:0]  div_dvd, quot;
    logic [DVR_W-1:0]  div_dvr;

    // result register
    logic                out_valid_reg;
    logic [COL_W-1:0]    column_out_reg, tex_x_reg;
    logic                status_reg, side_out_reg;
    logic [CELL_W-1:0]   hit_x_reg, hit_y_reg;
    logic [1:0]          face_reg;
    logic [PERP_W-1:0]   perp_out_reg;
    logic [LH_W-1:0]     lh_out_reg;
    logic [ROW_W-1:0]    ds_reg, de_reg;
    logic                fin;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_x_reg     <= POS_W'(2048);
            pos_y_reg     <= POS_W'(2048);
            dir_x_reg     <= -VEC_W'(16384);
            dir_y_reg     <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= VEC_W'(10813);
            tex_width_reg <= TEXW_W'(64);
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                REG_POS_X:     pos_x_reg     <= cfg_data;
                REG_POS_Y:     pos_y_reg     <= cfg_data;
                REG_DIR_X:     dir_x_reg     <= cfg_data;
                REG_DIR_Y:     dir_y_reg     <= cfg_data;
                REG_PLANE_X:   plane_x_reg   <= cfg_data;
                REG_PLANE_Y:   plane_y_reg   <= cfg_data;
                REG_TEX_WIDTH: tex_width_reg <= cfg_data[TEXW_W-1:0];
                default:       ;
            endcase
        end
    end

    // ---- grid memory ----
    assign mem_we    = (cmd.op == DP_CLEAR) || (cmd.op == DP_WRITE);
    assign mem_waddr = (cmd.op == DP_CLEAR) ? clr_cnt_reg[ADDR_W-1:0] : {cell_y, cell_x};
    assign mem_wdata = (cmd.op == DP_CLEAR) ? 1'b0 : wall_bit;
    // read the cell the walk moves into, so its bit is ready next cycle
    assign rd_addr   = {map_y_nx[CELL_W-1:0], map_x_nx[CELL_W-1:0]};

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_waddr] <= mem_wdata;
        end
        rd_reg <= grid_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.op == DP_CLEAR)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
        end
    end

    // ---- ray terms ----
    assign cam_prod  = CAMP_W'(column_reg) * CAMP_W'(CAM_MUL);
    assign neg_x  = ray_x_reg[RAY_W-1];
    assign neg_y  = ray_y_reg[RAY_W-1];
    assign zero_x = (ray_x_reg == '0);
    assign zero_y = (ray_y_reg == '0);
    assign abs_x  = neg_x ? (~ray_x_reg + 1'b1) : ray_x_reg;
    assign abs_y  = neg_y ? (~ray_y_reg + 1'b1) : ray_y_reg;
    assign prod_x_sh = prod_x_reg >>> 16;
    assign prod_y_sh = prod_y_reg >>> 16;

    // distance to the first grid line, Q10
    assign dist_x = neg_x ? {1'b0, pos_x_reg[9:0]} : (TEXW_W'(1024) - {1'b0, pos_x_reg[9:0]});
    assign dist_y = neg_y ? {1'b0, pos_y_reg[9:0]} : (TEXW_W'(1024) - {1'b0, pos_y_reg[9:0]});
    assign mul_x  = 42'(dist_x) * 42'(dlt_x_reg[30:0]);
    assign mul_y  = 42'(dist_y) * 42'(dlt_y_reg[30:0]);

    // ---- DDA step (ties go to y) ----
    always_comb
    begin
        take_x   = (sd_x_reg < sd_y_reg);
        sd_x_nx  = sd_x_reg;
        sd_y_nx  = sd_y_reg;
        map_x_nx = map_x_reg;
        map_y_nx = map_y_reg;
        if (take_x)
        begin
            sd_x_nx  = sd_x_reg + SD_W'(dlt_x_reg);
            map_x_nx = neg_x ? (map_x_reg - 1'b1) : (map_x_reg + 1'b1);
        end
        else
        begin
            sd_y_nx  = sd_y_reg + SD_W'(dlt_y_reg);
            map_y_nx = neg_y ? (map_y_reg - 1'b1) : (map_y_reg + 1'b1);
        end
    end

    // ---- hit geometry ----
    assign map_c   = side_reg ? map_y_reg : map_x_reg;
    assign pos_c   = side_reg ? pos_y_reg : pos_x_reg;
    assign pos_o   = side_reg ? pos_x_reg : pos_y_reg;
    assign neg_c   = side_reg ? neg_y : neg_x;
    assign zero_c  = side_reg ? zero_y : zero_x;
    assign ray_o   = side_reg ? ray_x_reg : ray_y_reg;
    assign num     = $signed({2'b00, map_c[CELL_W-1:0], 10'd0}) - $signed({2'b00, pos_c})
                     + (neg_c ? 18'sd1024 : 18'sd0);
    assign num_neg = -num;
    assign num_abs = num[NUM_W] ? num_neg[NUM_W-1:0] : num[NUM_W-1:0];

    assign frac   = {pos_o[9:0], 6'd0} + wprod_reg[29:14];
    assign tw     = (tex_width_reg == '0) ? TEXW_W'(1)
                  : ((tex_width_reg > TEXW_W'(1024)) ? TEXW_W'(1024) : tex_width_reg);
    assign tx_raw = txp_reg[TXP_W-1:16];
    assign tx_m   = tw - tx_raw - 1'b1;
    assign half   = lh_reg[LH_W-1:1];
    assign de_sum = {1'b0, half} + LH_W'(HALF_H);

    // ---- divider ----
    always_comb
    begin
        case (cmd.div_sel)
            DIV_DX:
            begin
                div_dvd = DVD_DLT;
                div_dvr = DVR_W'(abs_x);
            end
            DIV_DY:
            begin
                div_dvd = DVD_DLT;
                div_dvr = DVR_W'(abs_y);
            end
            DIV_PERP:
            begin
                div_dvd = DVD_W'({num_abs, 20'd0});
                div_dvr = DVR_W'(side_reg ? abs_y : abs_x);
            end
            DIV_LH:
            begin
                div_dvd = DVD_LH;
                div_dvr = perp_reg;
            end
            default:
            begin
                div_dvd = '0;
                div_dvr = '0;
            end
        endcase
    end

    assign div_start = (cmd.op == DP_DIV_GO);

    grc_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvr),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (quot)
    );

    // ---- cast registers ----
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                column_reg <= column;
            end
            DP_DIV_SAVE:
            begin
                case (cmd.div_sel)
                    DIV_CAM:  cam_reg <= CAM_W'(cam_prod[CAMP_W-1:CAM_SH]) - CAM_W'(65536);
                    DIV_DX:   dlt_x_reg <= zero_x ? DLT_INF : DLT_W'(quot);
                    DIV_DY:   dlt_y_reg <= zero_y ? DLT_INF : DLT_W'(quot);
                    DIV_PERP: perp_reg <= (zero_c || (|quot[DVD_W-1:PERP_W])) ? PERP_MAX
                                          : quot[PERP_W-1:0];
                    DIV_LH:   lh_reg <= ((perp_reg == '0) || (|quot[DVD_W-1:LH_W])) ? LH_MAX
                                        : quot[LH_W-1:0];
                    default:  ;
                endcase
            end
            DP_RAY_MUL:
            begin
                prod_x_reg <= plane_x_reg * cam_reg;
                prod_y_reg <= plane_y_reg * cam_reg;
            end
            DP_RAY_ADD:
            begin
                ray_x_reg <= {{(RAY_W-VEC_W){dir_x_reg[VEC_W-1]}}, dir_x_reg}
                             + prod_x_sh[RAY_W-1:0];
                ray_y_reg <= {{(RAY_W-VEC_W){dir_y_reg[VEC_W-1]}}, dir_y_reg}
                             + prod_y_sh[RAY_W-1:0];
            end
            DP_INIT:
            begin
                map_x_reg <= MAP_W'(pos_x_reg[POS_W-1:10]);
                map_y_reg <= MAP_W'(pos_y_reg[POS_W-1:10]);
                sd_x_reg  <= zero_x ? SD_W'({dist_x, 30'd0}) : SD_W'(mul_x[41:10]);
                sd_y_reg  <= zero_y ? SD_W'({dist_y, 30'd0}) : SD_W'(mul_y[41:10]);
            end
            DP_STEP:
            begin
                map_x_reg <= map_x_nx;
                map_y_reg <= map_y_nx;
                sd_x_reg  <= sd_x_nx;
                sd_y_reg  <= sd_y_nx;
                side_reg  <= !take_x;
            end
            DP_TEX_MUL:
            begin
                wprod_reg <= $signed({1'b0, perp_reg}) * ray_o;
            end
            DP_TEX_FRAC:
            begin
                txp_reg <= TXP_W'(frac) * TXP_W'(tw);
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.op == DP_INIT)
        begin
            step_cnt_reg <= '0;
        end
        else if (cmd.op == DP_STEP)
        begin
            step_cnt_reg <= step_cnt_reg + 1'b1;
        end
    end

    // ---- result register ----
    assign fin = (cmd.op == DP_FIN_HIT) || (cmd.op == DP_FIN_MISS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (fin)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.op == DP_FIN_HIT)
        begin
            column_out_reg <= column_reg;
            status_reg     <= 1'b0;
            hit_x_reg      <= map_x_reg[CELL_W-1:0];
            hit_y_reg      <= map_y_reg[CELL_W-1:0];
            side_out_reg   <= side_reg;
            face_reg       <= side_reg ? {1'b0, !neg_y} : {1'b1, !neg_x};
            perp_out_reg   <= perp_reg;
            lh_out_reg     <= lh_reg;
            ds_reg         <= (half > (LH_W-1)'(HALF_H)) ? '0 : ROW_W'((LH_W-1)'(HALF_H) - half);
            de_reg         <= (de_sum >= LH_W'(SCREEN_HEIGHT)) ? ROW_W'(SCREEN_HEIGHT - 1)
                              : de_sum[ROW_W-1:0];
            // mirrored on east-looking x crossings and north-looking y crossings
            tex_x_reg      <= ((!side_reg && !neg_x && !zero_x) || (side_reg && neg_y))
                              ? tx_m[COL_W-1:0] : tx_raw[COL_W-1:0];
        end
        else if (cmd.op == DP_FIN_MISS)
        begin
            column_out_reg <= column_reg;
            status_reg     <= 1'b1;
            hit_x_reg      <= '0;
            hit_y_reg      <= '0;
            side_out_reg   <= 1'b0;
            face_reg       <= '0;
            perp_out_reg   <= '0;
            lh_out_reg     <= '0;
            ds_reg         <= '0;
            de_reg         <= '0;
            tex_x_reg      <= '0;
        end
    end

    assign out_valid   = out_valid_reg;
    assign column_out  = column_out_reg;
    assign status      = status_reg;
    assign hit_x       = hit_x_reg;
    assign hit_y       = hit_y_reg;
    assign side        = side_out_reg;
    assign face        = face_reg;
    assign perp_dist   = perp_out_reg;
    assign line_height = lh_out_reg;
    assign draw_start  = ds_reg;
    assign draw_end    = de_reg;
    assign tex_x       = tex_x_reg;

    // ---- status to controller ----
    always_comb
    begin
        sts.clr_done = clr_cnt_reg[ADDR_W];
        sts.div_busy = div_busy;
        sts.div_done = div_done;
        sts.oob      = map_x_reg[MAP_W-1] || map_y_reg[MAP_W-1]
                       || (map_x_reg >= MAP_W'(MAP_SIZE)) || (map_y_reg >= MAP_W'(MAP_SIZE));
        sts.wall     = rd_reg;
        sts.step_lim = (step_cnt_reg == STEP_W'(MAX_STEPS));
        sts.out_busy = out_valid_reg && !out_ready;
    end

endmodule

### src/grc_ctrl.sv
// Controller state machine: sequences clear, map writes and the column cast.
// Depends on grc_pkg; drives the datapath by command word.
module grc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              opcode,
    output logic              in_ready,
    input  grc_pkg::dp_sts_t  sts,
    output grc_pkg::dp_cmd_t  cmd
);
    import grc_pkg::*;

    ctrl_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR:    if (sts.clr_done) state_next = ST_IDLE;
            ST_IDLE:     if (in_valid && (opcode == OPC_CAST)) state_next = ST_CAM;
            ST_CAM:      state_next = ST_RAY_MUL;
            ST_RAY_MUL:  state_next = ST_RAY_ADD;
            ST_RAY_ADD:  state_next = ST_DX;
            ST_DX:       state_next = ST_DX_W;
            ST_DX_W:     if (sts.div_done) state_next = ST_DY;
            ST_DY:       state_next = ST_DY_W;
            ST_DY_W:     if (sts.div_done) state_next = ST_INIT;
            ST_INIT:     state_next = ST_STEP;
            ST_STEP:     state_next = ST_CHK;
            ST_CHK:
            begin
                // leaving the grid wins over a wall bit read from a wrapped address
                if (sts.oob || (!sts.wall && sts.step_lim))
                begin
                    state_next = ST_MISS;
                end
                else if (sts.wall)
                begin
                    state_next = ST_PERP;
                end
            end
            ST_PERP:     state_next = ST_PERP_W;
            ST_PERP_W:   if (sts.div_done) state_next = ST_LH;
            ST_LH:       state_next = ST_LH_W;
            ST_LH_W:     if (sts.div_done) state_next = ST_TEX_MUL;
            ST_TEX_MUL:  state_next = ST_TEX_FRAC;
            ST_TEX_FRAC: state_next = ST_FIN;
            ST_FIN:      if (!sts.out_busy) state_next = ST_IDLE;
            ST_MISS:     if (!sts.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd.op      = DP_NOP;
        cmd.div_sel = DIV_CAM;
        in_ready    = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                if (!sts.clr_done) cmd.op = DP_CLEAR;
            end
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.op = (opcode == OPC_CAST) ? DP_LOAD : DP_WRITE;
                end
            end
            ST_CAM:
            begin
                // camera offset comes from a reciprocal multiply, no divider pass
                cmd.op = DP_DIV_SAVE;
            end
            ST_RAY_MUL:  cmd.op = DP_RAY_MUL;
            ST_RAY_ADD:  cmd.op = DP_RAY_ADD;
            ST_DX:
            begin
                cmd.op      = DP_DIV_GO;
                cmd.div_sel = DIV_DX;
            end
            ST_DX_W:
            begin
                cmd.div_sel = DIV_DX;
                if (sts.div_done) cmd.op = DP_DIV_SAVE;
            end
            ST_DY:
            begin
                cmd.op      = DP_DIV_GO;
                cmd.div_sel = DIV_DY;
            end
            ST_DY_W:
            begin
                cmd.div_sel = DIV_DY;
                if (sts.div_done) cmd.op = DP_DIV_SAVE;
            end
            ST_INIT:     cmd.op = DP_INIT;
            ST_STEP:     cmd.op = DP_STEP;
            ST_CHK:
            begin
                if (!sts.oob && !sts.wall && !sts.step_lim) cmd.op = DP_STEP;
            end
            ST_PERP:
            begin
                cmd.op      = DP_DIV_GO;
                cmd.div_sel = DIV_PERP;
            end
            ST_PERP_W:
            begin
                cmd.div_sel = DIV_PERP;
                if (sts.div_done) cmd.op = DP_DIV_SAVE;
            end
            ST_LH:
            begin
                cmd.op      = DP_DIV_GO;
                cmd.div_sel = DIV_LH;
            end
            ST_LH_W:
            begin
                cmd.div_sel = DIV_LH;
                if (sts.div_done) cmd.op = DP_DIV_SAVE;
            end
            ST_TEX_MUL:  cmd.op = DP_TEX_MUL;
            ST_TEX_FRAC: cmd.op = DP_TEX_FRAC;
            ST_FIN:
            begin
                if (!sts.out_busy) cmd.op = DP_FIN_HIT;
            end
            ST_MISS:
            begin
                if (!sts.out_busy) cmd.op = DP_FIN_MISS;
            end
            default: ;
        endcase
    end

endmodule

### src/grid_ray_caster_column.sv
// Top level of the grid ray caster column block.
// Depends on grc_pkg, grc_ctrl and grc_dp (which holds grc_div).
//
//   channel  | handshake            | payload
//   ---------+----------------------+------------------------------------------
//   in       | in_valid / in_ready  | opcode, cell_x, cell_y, wall_bit, column
//   out      | out_valid / out_ready| column_out, status, hit_x .. tex_x
//   cfg      | cfg_we               | cfg_addr, cfg_data
//
// A cast walks up to 128 grid cells, whether it hits a wall, leaves the grid or
// runs out of steps. Four divisions share the bit-serial divider (two for a miss),
// and the walk moves one cell per cycle on the grid memory read port. After reset
// a pass clears the grid; in_ready stays low meanwhile. A finished result waits in
// the output register; the next word is taken meanwhile and only its own result
// stalls on out_ready.
module grid_ray_caster_column (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_we,
    input  logic [grc_pkg::CFG_A_W-1:0]  cfg_addr,
    input  logic [grc_pkg::VEC_W-1:0]    cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic                         opcode,
    input  logic [grc_pkg::CELL_W-1:0]   cell_x,
    input  logic [grc_pkg::CELL_W-1:0]   cell_y,
    input  logic                         wall_bit,
    input  logic [grc_pkg::COL_W-1:0]    column,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [grc_pkg::COL_W-1:0]    column_out,
    output logic                         status,
    output logic [grc_pkg::CELL_W-1:0]   hit_x,
    output logic [grc_pkg::CELL_W-1:0]   hit_y,
    output logic                         side,
    output logic [1:0]                   face,
    output logic [grc_pkg::PERP_W-1:0]   perp_dist,
    output logic [grc_pkg::LH_W-1:0]     line_height,
    output logic [grc_pkg::ROW_W-1:0]    draw_start,
    output logic [grc_pkg::ROW_W-1:0]    draw_end,
    output logic [grc_pkg::COL_W-1:0]    tex_x
);
    import grc_pkg::*;

    dp_cmd_t cmd;
    dp_sts_t sts;

    grc_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .opcode   (opcode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    grc_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_addr    (cfg_addr),
        .cfg_data    (cfg_data),
        .cell_x      (cell_x),
        .cell_y      (cell_y),
        .wall_bit    (wall_bit),
        .column      (column),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .column_out  (column_out),
        .status      (status),
        .hit_x       (hit_x),
        .hit_y       (hit_y),
        .side        (side),
        .face        (face),
        .perp_dist   (perp_dist),
        .line_height (line_height),
        .draw_start  (draw_start),
        .draw_end    (draw_end),
        .tex_x       (tex_x)
    );

    a_ready_after_clear: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> sts.clr_done)
        else $error("input taken before grid clear finished");

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_DIV_GO) |-> !sts.div_busy)
        else $error("divider restarted while busy");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.op == DP_STEP) |-> !sts.step_lim)
        else $error("walk stepped past the step limit");

    a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
        ((cmd.op == DP_FIN_HIT) || (cmd.op == DP_FIN_MISS)) |=> out_valid)
        else $error("result load did not raise out_valid");

endmodule
